>>> rtl/core/multi_channel_periodic_timer_unit_macros.svh
// assertion macros used by the timer unit checker
`ifndef MULTI_CHANNEL_PERIODIC_TIMER_UNIT_MACROS_SVH
`define MULTI_CHANNEL_PERIODIC_TIMER_UNIT_MACROS_SVH

// same-cycle implication
`define MCPT_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("timer unit assertion failed");

// next-cycle implication
`define MCPT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("timer unit assertion failed");

`endif

>>> rtl/core/mcpt_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package mcpt_pkg;

    localparam int NUM_TIMERS_DEFAULT = 16;
    localparam int OP_W               = 4;
    localparam int ID_W               = 4;
    localparam int DATA_W             = 32;
    localparam int MAX_FIRED          = 16;
    localparam int FIRE_CNT_W         = $clog2(MAX_FIRED + 1);

    localparam logic [OP_W-1:0] OP_REGISTER   = 4'd0;
    localparam logic [OP_W-1:0] OP_UNREGISTER = 4'd1;
    localparam logic [OP_W-1:0] OP_START      = 4'd2;
    localparam logic [OP_W-1:0] OP_RESTART    = 4'd3;
    localparam logic [OP_W-1:0] OP_STOP       = 4'd4;
    localparam logic [OP_W-1:0] OP_CLEAR_ALL  = 4'd5;
    localparam logic [OP_W-1:0] OP_TICK       = 4'd6;
    localparam logic [OP_W-1:0] OP_PROCESS    = 4'd7;
    localparam logic [OP_W-1:0] OP_READ_PER   = 4'd8;
    localparam logic [OP_W-1:0] OP_SET_COUNT  = 4'd9;

    localparam logic [DATA_W-1:0] COUNT_MAX = '1;

    // command token that walks down the chain of timer cells
    typedef struct packed {
        logic                  valid;
        logic [OP_W-1:0]       op;
        logic [ID_W-1:0]       timer_id;
        logic [DATA_W-1:0]     value;
        logic [DATA_W-1:0]     per_out;
        logic [FIRE_CNT_W-1:0] nfired;
    } wave_t;

endpackage

`default_nettype wire

>>> rtl/core/mcpt_cell.sv
`timescale 1ns / 1ps
`default_nettype none

module mcpt_cell
    import mcpt_pkg::*;
#(
    parameter int NUM_TIMERS = NUM_TIMERS_DEFAULT,
    parameter int IDX        = 0
)
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire wave_t wave_in,
    output wave_t      wave_out,
    output logic       fire
);

    localparam int IXW = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
    localparam int CW  = (IXW > ID_W) ? IXW : ID_W;

    logic              registered_reg, registered_next;
    logic              running_reg, running_next;
    logic [DATA_W-1:0] count_reg, count_next;
    logic [DATA_W-1:0] period_reg, period_next;
    logic              valid_reg;
    wave_t             wave_reg, wave_next;
    logic              hit;
    logic              armed;

    assign hit   = wave_in.valid && (CW'(wave_in.timer_id) == CW'(IDX));
    assign armed = running_reg && registered_reg;

    always_comb
    begin
        registered_next = registered_reg;
        running_next    = running_reg;
        count_next      = count_reg;
        period_next     = period_reg;
        wave_next       = wave_in;
        fire            = 1'b0;
        if (wave_in.valid)
        begin
            case (wave_in.op)
                OP_REGISTER:
                begin
                    if (hit && !registered_reg)
                    begin
                        count_next      = '0;
                        registered_next = 1'b1;
                    end
                end
                OP_UNREGISTER:
                begin
                    if (hit)
                    begin
                        registered_next = 1'b0;
                    end
                end
                OP_START:
                begin
                    if (hit && registered_reg)
                    begin
                        running_next = 1'b1;
                        count_next   = '0;
                        period_next  = wave_in.value;
                    end
                end
                OP_RESTART:
                begin
                    if (hit && registered_reg)
                    begin
                        running_next = 1'b1;
                        count_next   = '0;
                    end
                end
                OP_STOP:
                begin
                    if (hit && registered_reg)
                    begin
                        running_next = 1'b0;
                        count_next   = '0;
                        period_next  = '0;
                    end
                end
                OP_CLEAR_ALL:
                begin
                    registered_next = 1'b0;
                    running_next    = 1'b0;
                    count_next      = '0;
                    period_next     = '0;
                end
                OP_TICK:
                begin
                    if (armed && (count_reg != COUNT_MAX))
                    begin
                        count_next = count_reg + DATA_W'(1);
                    end
                end
                OP_PROCESS:
                begin
                    if (armed && (count_reg >= period_reg)
                        && (wave_in.nfired < FIRE_CNT_W'(MAX_FIRED)))
                    begin
                        count_next       = '0;
                        fire             = 1'b1;
                        wave_next.nfired = wave_in.nfired + FIRE_CNT_W'(1);
                    end
                end
                OP_READ_PER:
                begin
                    if (hit && registered_reg)
                    begin
                        wave_next.per_out = period_reg;
                    end
                end
                OP_SET_COUNT:
                begin
                    if (hit)
                    begin
                        count_next = wave_in.value;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            registered_reg <= 1'b0;
            running_reg    <= 1'b0;
            count_reg      <= '0;
            period_reg     <= '0;
            valid_reg      <= 1'b0;
        end
        else
        begin
            registered_reg <= registered_next;
            running_reg    <= running_next;
            count_reg      <= count_next;
            period_reg     <= period_next;
            valid_reg      <= wave_in.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        wave_reg <= wave_next;
    end

    always_comb
    begin
        wave_out       = wave_reg;
        wave_out.valid = valid_reg;
    end

endmodule

`default_nettype wire

>>> rtl/core/multi_channel_periodic_timer_unit.sv
// Bank of NUM_TIMERS periodic timers held in a chain of timer cells, one
// timer per cell. An accepted item becomes a command token that walks down
// the chain one cell per cycle, from the launch register through the
// register of each cell, and its first result is then registered in the
// output register. A process item then reports its expired timers in
// ascending id order, scanning one timer per cycle while the output is not
// stalled (at most 16 are reported per item). Every other item, and a
// process item that finds nothing, gives one result with last set. The
// next item is taken only once the last result of the current one has
// entered the output register, so the block takes no new item before it is
// through with the current one.
`timescale 1ns / 1ps
`default_nettype none

module multi_channel_periodic_timer_unit
    import mcpt_pkg::*;
#(
    parameter int NUM_TIMERS = NUM_TIMERS_DEFAULT
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_stall,
    input  wire logic [OP_W-1:0]   op,
    input  wire logic [ID_W-1:0]   timer_id,
    input  wire logic [DATA_W-1:0] value,
    output logic                   out_valid,
    input  wire logic              out_stall,
    output logic                   fired,
    output logic [ID_W-1:0]        fired_id,
    output logic [DATA_W-1:0]      period_out,
    output logic                   last
);

    localparam int IXW = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_WALK   = 4'b0010,
        ST_SCAN   = 4'b0100,
        ST_SINGLE = 4'b1000
    } state_t;

    state_t                  state_reg, state_next;
    wave_t                   launch_reg;
    logic                    launch_valid_reg;
    wave_t                   chain [0:NUM_TIMERS];
    logic [NUM_TIMERS-1:0]   fire_vec;
    logic [NUM_TIMERS-1:0]   mask_reg, mask_next;
    logic [IXW-1:0]          idx_reg, idx_next;
    logic [DATA_W-1:0]       per_reg, per_next;
    logic                    accept;
    logic                    can_push;
    logic                    push;
    logic                    push_fired;
    logic [ID_W-1:0]         push_id;
    logic [DATA_W-1:0]       push_per;
    logic                    push_last;
    logic                    rest_any;
    logic                    out_valid_reg;
    logic                    fired_reg;
    logic [ID_W-1:0]         fired_id_reg;
    logic [DATA_W-1:0]       period_out_reg;
    logic                    last_reg;

    assign in_stall = (state_reg != ST_IDLE);
    assign accept   = in_valid && !in_stall;
    assign can_push = !out_valid_reg || !out_stall;
    assign rest_any = ((mask_reg >> 1) != '0);

    always_comb
    begin
        chain[0]       = launch_reg;
        chain[0].valid = launch_valid_reg;
    end

    for (genvar i = 0; i < NUM_TIMERS; i++)
    begin : g_cell
        mcpt_cell #(
            .NUM_TIMERS (NUM_TIMERS),
            .IDX        (i)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .wave_in  (chain[i]),
            .wave_out (chain[i+1]),
            .fire     (fire_vec[i])
        );
    end

    always_comb
    begin
        state_next = state_reg;
        mask_next  = mask_reg;
        idx_next   = idx_reg;
        per_next   = per_reg;
        push       = 1'b0;
        push_fired = 1'b0;
        push_id    = '0;
        push_per   = '0;
        push_last  = 1'b1;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    mask_next  = '0;
                    state_next = ST_WALK;
                end
            end
            ST_WALK:
            begin
                mask_next = mask_reg | fire_vec;
                if (chain[NUM_TIMERS].valid)
                begin
                    per_next = chain[NUM_TIMERS].per_out;
                    idx_next = '0;
                    if (mask_reg == '0)
                    begin
                        state_next = ST_SINGLE;
                    end
                    else
                    begin
                        state_next = ST_SCAN;
                    end
                end
            end
            ST_SCAN:
            begin
                if (mask_reg[0])
                begin
                    if (can_push)
                    begin
                        push       = 1'b1;
                        push_fired = 1'b1;
                        push_id    = ID_W'(idx_reg);
                        push_last  = !rest_any;
                        mask_next  = mask_reg >> 1;
                        idx_next   = idx_reg + IXW'(1);
                        if (!rest_any)
                        begin
                            state_next = ST_IDLE;
                        end
                    end
                end
                else
                begin
                    mask_next = mask_reg >> 1;
                    idx_next  = idx_reg + IXW'(1);
                end
            end
            ST_SINGLE:
            begin
                if (can_push)
                begin
                    push       = 1'b1;
                    push_per   = per_reg;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            launch_valid_reg <= 1'b0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            launch_valid_reg <= accept;
            out_valid_reg    <= push || (out_valid_reg && out_stall);
        end
    end

    always_ff @(posedge clk)
    begin
        mask_reg <= mask_next;
        idx_reg  <= idx_next;
        per_reg  <= per_next;
        if (accept)
        begin
            launch_reg.valid    <= 1'b1;
            launch_reg.op       <= op;
            launch_reg.timer_id <= timer_id;
            launch_reg.value    <= value;
            launch_reg.per_out  <= '0;
            launch_reg.nfired   <= '0;
        end
        if (push)
        begin
            fired_reg      <= push_fired;
            fired_id_reg   <= push_id;
            period_out_reg <= push_per;
            last_reg       <= push_last;
        end
    end

    assign out_valid  = out_valid_reg;
    assign fired      = fired_reg;
    assign fired_id   = fired_id_reg;
    assign period_out = period_out_reg;
    assign last       = last_reg;

endmodule

`default_nettype wire

>>> rtl/core/mcpt_checker.sv
`timescale 1ns / 1ps
`default_nettype none

`include "multi_channel_periodic_timer_unit_macros.svh"

module mcpt_checker
    import mcpt_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    input  wire logic              in_stall,
    input  wire logic              out_valid,
    input  wire logic              out_stall,
    input  wire logic              fired,
    input  wire logic [ID_W-1:0]   fired_id,
    input  wire logic [DATA_W-1:0] period_out,
    input  wire logic              last
);

    // a result without an expiry is always the only one of its item
    `MCPT_ASSERT_NOW(a_plain_result, clk, rst_n, (out_valid && !fired), (fired_id == '0 && last))

    // an expiry result carries no period
    `MCPT_ASSERT_NOW(a_fire_no_period, clk, rst_n, (out_valid && fired), (period_out == '0))

    // one item at a time: an accepted item keeps the input side busy
    `MCPT_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, (in_valid && !in_stall), (in_stall))

    // stalled result holds
    `MCPT_ASSERT_NEXT(a_out_hold, clk, rst_n, (out_valid && out_stall), (out_valid && $stable(fired) && $stable(fired_id) && $stable(period_out) && $stable(last)))

endmodule

bind multi_channel_periodic_timer_unit mcpt_checker u_mcpt_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .fired      (fired),
    .fired_id   (fired_id),
    .period_out (period_out),
    .last       (last)
);

`default_nettype wire
